// ----- src/sspd_pkg.sv -----
// Shared types and constants for the servo status packet deframer.
package sspd_pkg;

    localparam int BYTE_W = 8;
    localparam int POS_W  = 9;

    localparam logic [BYTE_W-1:0] HDR_BYTE = 8'hFF;

    typedef enum logic [2:0] {
        PH_HUNT1,
        PH_HUNT2,
        PH_ID,
        PH_LEN,
        PH_BODY
    } phase_t;

    typedef struct packed {
        logic              checksum_ok;
        logic              last;
        logic [POS_W-1:0]  byte_pos;
        logic [BYTE_W-1:0] packet_byte;
    } result_t;

endpackage

// ----- src/servo_status_packet_deframer_unit.sv -----
// Top level of the servo status packet deframer.
//
//   channel  dir  tdata (low bit up)                 tlast  tuser
//   s_*      in   rx_byte[7:0]                        -      -
//   m_*      out  packet_byte[7:0], byte_pos[16:8]    last   checksum_ok
//
// One word per cycle sustained while m_tready does not stall the output; each word
// passes through the input register and then the output register to m_tdata.
// Header and dropped words pass through the input register but give no output.
// Reset clears the framer to hunting for the first header word.
// A stall on m_tready holds the output register, then the input register,
// then drops s_tready.
module servo_status_packet_deframer_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte[7:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // packet_byte[7:0], byte_pos[16:8], zero pad
    output logic        m_tlast,
    output logic        m_tuser    // checksum_ok
);
    import sspd_pkg::*;

    logic    res_valid;
    result_t res;
    logic    out_free;
    result_t out_data;

    sspd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res)
    );

    sspd_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .out_free  (out_free),
        .valid     (m_tvalid),
        .ready     (m_tready),
        .data      (out_data)
    );

    assign m_tdata = {7'b0, out_data.byte_pos, out_data.packet_byte};
    assign m_tlast = out_data.last;
    assign m_tuser = out_data.checksum_ok;

endmodule

// ----- src/sspd_parser.sv -----
// Input word register and packet framing state machine.
module sspd_parser (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [sspd_pkg::BYTE_W-1:0] in_byte,
    input  logic                        out_free,
    output logic                        res_valid,
    output sspd_pkg::result_t           res
);
    import sspd_pkg::*;

    logic [BYTE_W-1:0] byte_reg;
    logic              full_reg;
    phase_t            phase_reg, phase_next;
    logic [POS_W-1:0]  left_reg, left_next;
    logic [BYTE_W-1:0] sum_reg, sum_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              fire;
    logic              emit;
    logic [POS_W-1:0]  pos_inc;
    logic [POS_W-1:0]  left_dec;
    logic              sum_match;

    assign fire      = full_reg && out_free;
    assign in_ready  = !full_reg || out_free;
    assign res_valid = full_reg && emit;
    assign pos_inc   = pos_reg + POS_W'(1);
    assign left_dec  = left_reg - POS_W'(1);
    assign sum_match = (~sum_reg) == byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            full_reg <= 1'b1;
        end
        else if (fire)
        begin
            full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= in_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT1;
            left_reg  <= '0;
            sum_reg   <= '0;
            pos_reg   <= '0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
            sum_reg   <= sum_next;
            pos_reg   <= pos_next;
        end
    end

    always_comb
    begin
        phase_next      = phase_reg;
        left_next       = left_reg;
        sum_next        = sum_reg;
        pos_next        = pos_reg;
        emit            = 1'b0;
        res.packet_byte = byte_reg;
        res.byte_pos    = pos_reg;
        res.last        = 1'b0;
        res.checksum_ok = 1'b0;
        case (phase_reg)
            PH_HUNT1:
            begin
                if (byte_reg == HDR_BYTE)
                begin
                    phase_next = PH_HUNT2;
                end
            end
            PH_HUNT2:
            begin
                phase_next = (byte_reg == HDR_BYTE) ? PH_ID : PH_HUNT1;
            end
            PH_ID:
            begin
                emit         = 1'b1;
                res.byte_pos = '0;
                pos_next     = '0;
                sum_next     = byte_reg;
                phase_next   = PH_LEN;
            end
            PH_LEN:
            begin
                emit         = 1'b1;
                res.byte_pos = POS_W'(1);
                pos_next     = POS_W'(1);
                if (byte_reg == '0)
                begin
                    res.last        = 1'b1;
                    res.checksum_ok = sum_match;
                    phase_next      = PH_HUNT1;
                    left_next       = '0;
                    sum_next        = '0;
                end
                else
                begin
                    sum_next   = sum_reg + byte_reg;
                    left_next  = POS_W'(byte_reg);
                    phase_next = PH_BODY;
                end
            end
            PH_BODY:
            begin
                emit         = 1'b1;
                res.byte_pos = pos_inc;
                pos_next     = pos_inc;
                left_next    = left_dec;
                if (left_dec == '0)
                begin
                    res.last        = 1'b1;
                    res.checksum_ok = sum_match;
                    phase_next      = PH_HUNT1;
                    sum_next        = '0;
                end
                else
                begin
                    sum_next = sum_reg + byte_reg;
                end
            end
            default:
            begin
                phase_next = PH_HUNT1;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_ok_needs_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.checksum_ok |-> res.last)
        else $error("checksum_ok set on a word that is not last");

    a_last_rehunts: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res_valid && res.last |=> phase_reg == PH_HUNT1)
        else $error("no return to hunting after last word");

    a_id_then_len: assert property (@(posedge clk) disable iff (!rst_n)
        fire && phase_reg == PH_ID |=> phase_reg == PH_LEN)
        else $error("id word not followed by length phase");

    a_hold_unfired: assert property (@(posedge clk) disable iff (!rst_n)
        full_reg && !out_free |=> full_reg && $stable(byte_reg))
        else $error("held input word lost while output stalled");
`endif

endmodule

// ----- src/sspd_out_reg.sv -----
// Output result register for the master-side stream.
module sspd_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              res_valid,
    input  sspd_pkg::result_t res,
    output logic              out_free,
    output logic              valid,
    input  logic              ready,
    output sspd_pkg::result_t data
);
    import sspd_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    assign out_free = !valid_reg || ready;
    assign valid    = valid_reg;
    assign data     = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && res_valid)
        begin
            data_reg <= res;
        end
    end

endmodule

// ----- bench/tb_top.sv -----
// Self-checking bench for the servo status packet deframer: directed table plus random traffic.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sspd_pkg::*;

    typedef struct {
        logic [7:0] rx;
        bit         typed;
        bit         typed_has;
        result_t    typed_res;
    } stim_row_t;

    localparam int NUM_ROWS   = 17;
    localparam int RAND_WORDS = 1750;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    // shadow framer state
    phase_t     frame_phase = PH_HUNT1;
    logic [8:0] bytes_to_go = '0;
    logic [7:0] byte_sum    = '0;
    logic [8:0] byte_idx    = '0;

    result_t pending_words[$];
    bit      calm = 1'b0;
    int      stall_left = 0;
    int      error_count = 0;
    int      words_sent = 0;
    int      words_out = 0;
    int      packets_closed = 0;
    int      sums_good = 0;
    int      long_packets = 0;

    stim_row_t dir_rows [NUM_ROWS];

    servo_status_packet_deframer_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #1 clk = ~clk;

    function automatic result_t word_of(logic [7:0] b, logic [8:0] pos, bit is_last, bit ok);
        result_t r;
        r.packet_byte = b;
        r.byte_pos    = pos;
        r.last        = is_last;
        r.checksum_ok = ok;
        return r;
    endfunction

    // Emits one packet word and folds it into the running sum; a last word clears the sum and returns to hunting.
    function automatic result_t frame_word(logic [7:0] b, logic [8:0] pos, bit is_last);
        bit ok;
        ok = is_last && (~byte_sum == b);
        if (is_last)
        begin
            frame_phase = PH_HUNT1;
            bytes_to_go = '0;
            byte_sum    = '0;
        end
        else
        begin
            byte_sum = byte_sum + b;
        end
        return word_of(b, pos, is_last, ok);
    endfunction

    function automatic bit deframe_byte(logic [7:0] b, output result_t r);
        r = '0;
        case (frame_phase)
            PH_HUNT1:
            begin
                if (b == HDR_BYTE)
                    frame_phase = PH_HUNT2;
                return 1'b0;
            end
            PH_HUNT2:
            begin
                frame_phase = (b == HDR_BYTE) ? PH_ID : PH_HUNT1;
                return 1'b0;
            end
            PH_ID:
            begin
                byte_sum = '0;
                byte_idx = '0;
                r = frame_word(b, 9'd0, 1'b0);
                frame_phase = PH_LEN;
                return 1'b1;
            end
            PH_LEN:
            begin
                byte_idx = 9'd1;
                if (b == 8'd0)
                begin
                    r = frame_word(b, 9'd1, 1'b1);
                end
                else
                begin
                    r = frame_word(b, 9'd1, 1'b0);
                    bytes_to_go = {1'b0, b};
                    frame_phase = PH_BODY;
                end
                return 1'b1;
            end
            PH_BODY:
            begin
                byte_idx    = byte_idx + 9'd1;
                bytes_to_go = bytes_to_go - 9'd1;
                r = frame_word(b, byte_idx, bytes_to_go == 9'd0);
                return 1'b1;
            end
            default:
            begin
                frame_phase = PH_HUNT1;
                return 1'b0;
            end
        endcase
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_word(input logic [7:0] b, input bit typed, input bit typed_has,
                             input result_t typed_res);
        int      gap;
        bit      has;
        bit      dropped;
        result_t r;
        gap = calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge clk); while (!s_tready);
        dropped = (frame_phase == PH_HUNT1) && (b != HDR_BYTE);
        has = deframe_byte(b, r);
        if (typed)
        begin
            has = typed_has;
            r   = typed_res;
        end
        if (has)
            pending_words = {pending_words, r};
        if (!dropped)
            words_sent++;
    endtask

    task automatic send_packet(input logic [7:0] id, input logic [7:0] len, input bit good);
        logic [7:0] sum;
        logic [7:0] b;
        sum = id + len;
        send_word(HDR_BYTE, 1'b0, 1'b0, '0);
        send_word(HDR_BYTE, 1'b0, 1'b0, '0);
        send_word(id, 1'b0, 1'b0, '0);
        send_word(len, 1'b0, 1'b0, '0);
        if (len != 8'd0)
        begin
            for (int i = 1; i < len; i++)
            begin
                b = 8'($urandom);
                sum = sum + b;
                send_word(b, 1'b0, 1'b0, '0);
            end
            b = good ? ~sum : 8'($urandom);
            send_word(b, 1'b0, 1'b0, '0);
        end
    endtask

    // output side backpressure
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
            if (!calm && $urandom_range(0, 5) == 0)
                stall_left = pick_gap();
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            words_out++;
            if (pending_words.size() == 0)
            begin
                $error("unexpected word: tdata %06h, tlast %0b, tuser %0b",
                       m_tdata, m_tlast, m_tuser);
                error_count++;
            end
            else
            begin
                want = pending_words.pop_front();
                if (m_tdata[7:0] !== want.packet_byte)
                begin
                    $error("packet_byte: expected %02h, got %02h",
                           want.packet_byte, m_tdata[7:0]);
                    error_count++;
                end
                if (m_tdata[16:8] !== want.byte_pos)
                begin
                    $error("byte_pos: expected %0d, got %0d", want.byte_pos, m_tdata[16:8]);
                    error_count++;
                end
                if (m_tlast !== want.last)
                begin
                    $error("last: expected %0b, got %0b", want.last, m_tlast);
                    error_count++;
                end
                if (m_tuser !== want.checksum_ok)
                begin
                    $error("checksum_ok: expected %0b, got %0b", want.checksum_ok, m_tuser);
                    error_count++;
                end
                if (want.last)
                begin
                    packets_closed++;
                    if (want.checksum_ok)
                        sums_good++;
                end
            end
        end
    end

    initial
    begin
        int         pick;
        int         pkt_count;
        int         noise_len;
        logic [7:0] len;
        logic [7:0] id;

        dir_rows = '{
            '{8'h00, 1'b1, 1'b0, '0},                                // dropped while hunting
            '{8'hFF, 1'b1, 1'b0, '0},
            '{8'h12, 1'b1, 1'b0, '0},                                // bad second header
            '{8'hFF, 1'b1, 1'b0, '0},
            '{8'hFF, 1'b1, 1'b0, '0},
            '{8'hFF, 1'b1, 1'b1, word_of(8'hFF, 9'd0, 1'b0, 1'b0)}, // id of all ones
            '{8'h00, 1'b1, 1'b1, word_of(8'h00, 9'd1, 1'b1, 1'b1)}, // zero length, good
            '{8'hFF, 1'b1, 1'b0, '0},
            '{8'hFF, 1'b1, 1'b0, '0},
            '{8'h01, 1'b0, 1'b0, '0},
            '{8'h02, 1'b0, 1'b0, '0},
            '{8'hAA, 1'b0, 1'b0, '0},
            '{8'h52, 1'b1, 1'b1, word_of(8'h52, 9'd3, 1'b1, 1'b1)},
            '{8'hFF, 1'b1, 1'b0, '0},
            '{8'hFF, 1'b1, 1'b0, '0},
            '{8'h00, 1'b1, 1'b1, word_of(8'h00, 9'd0, 1'b0, 1'b0)},
            '{8'h00, 1'b1, 1'b1, word_of(8'h00, 9'd1, 1'b1, 1'b0)}  // zero length, bad
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_word(dir_rows[i].rx, dir_rows[i].typed, dir_rows[i].typed_has,
                      dir_rows[i].typed_res);

        pkt_count = 0;
        words_sent = 0;
        while (words_sent < RAND_WORDS)
        begin
            calm = ($urandom_range(0, 7) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 80)
            begin
                if (pkt_count % 120 == 0)
                begin
                    len = 8'd255;
                    long_packets++;
                end
                else if ($urandom_range(0, 99) < 70)
                begin
                    len = 8'($urandom_range(0, 6));
                end
                else
                begin
                    len = 8'($urandom_range(7, 40));
                end
                id = ($urandom_range(0, 9) == 0) ? HDR_BYTE : 8'($urandom);
                send_packet(id, len, $urandom_range(0, 3) != 0);
                pkt_count++;
            end
            else if (pick < 90)
            begin
                send_word(HDR_BYTE, 1'b0, 1'b0, '0);
                send_word(8'($urandom_range(0, 254)), 1'b0, 1'b0, '0);
            end
            else
            begin
                noise_len = $urandom_range(1, 4);
                repeat (noise_len) send_word(8'($urandom), 1'b0, 1'b0, '0);
            end
        end
        s_tvalid <= 1'b0;

        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Summary: %0d random packets (%0d of length 255), %0d input words counted",
                 pkt_count, long_packets, words_sent);
        $display("Summary: %0d output words, %0d packets closed, %0d with matching checksum",
                 words_out, packets_closed, sums_good);
        if (error_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("tb_top: errors");
        $finish;
    end

endmodule

// ----- files.f -----
src/sspd_pkg.sv
src/sspd_parser.sv
src/sspd_out_reg.sv
src/servo_status_packet_deframer_unit.sv
bench/tb_top.sv
